// File: rtl/tcfp_pkg.sv
// ----------------------------------------------------------------------------
// tcfp_pkg
// Shared types and codes of the external term format clock parser.
// ----------------------------------------------------------------------------
package tcfp_pkg;

   // Fixed actor width in bytes.
   localparam int ActorBytes = 8;

   // Result kinds.
   localparam logic [2:0] KIND_PAIR  = 3'd0;
   localparam logic [2:0] KIND_DOT   = 3'd1;
   localparam logic [2:0] KIND_EMPTY = 3'd2;
   localparam logic [2:0] KIND_DONE  = 3'd3;
   localparam logic [2:0] KIND_ERR   = 3'd4;

   // Error codes.
   localparam logic [3:0] ERR_NONE  = 4'd0;
   localparam logic [3:0] ERR_MAGIC = 4'd1;
   localparam logic [3:0] ERR_TUPLE = 4'd2;
   localparam logic [3:0] ERR_LIST  = 4'd3;
   localparam logic [3:0] ERR_ACTOR = 4'd4;
   localparam logic [3:0] ERR_INT   = 4'd5;
   localparam logic [3:0] ERR_BIG   = 4'd6;
   localparam logic [3:0] ERR_DUP   = 4'd7;
   localparam logic [3:0] ERR_TAIL  = 4'd8;
   localparam logic [3:0] ERR_SHORT = 4'd9;
   localparam logic [3:0] ERR_COUNT = 4'd10;
   localparam logic [3:0] ERR_FULL  = 4'd11;

   // Input item.
   typedef struct packed {
      logic        action;
      logic [23:0] value_length;
      logic [7:0]  data_byte;
   } tcfp_req_type;

   // Result item.
   typedef struct packed {
      logic [2:0]  kind;
      logic [63:0] actor_id;
      logic [63:0] event_count;
      logic [3:0]  error_code;
      logic        final_res;
   } tcfp_rsp_type;

   // Status of the actor search unit.
   typedef struct packed {
      logic done;
      logic dup;
   } tcfp_srch_type;

endpackage

// File: rtl/term_format_clock_parser.sv
// ----------------------------------------------------------------------------
// term_format_clock_parser
// Streaming parser of a clock value in external term format.
// ----------------------------------------------------------------------------
// A start transfer gives the value's length, then one data byte per transfer
// follows; req_stall stays high until all results of a byte are taken.
// The last byte of an actor starts a search of the actor table through a
// single read port and comparator, one entry per cycle, over the N actors
// already seen in the current section (at most MAX_ACTORS). Results come
// out in order with final_res marking the last result of each input transfer.
module term_format_clock_parser import tcfp_pkg::*; #(
   parameter int MAX_ACTORS    = 16,
   parameter int COUNTER_BYTES = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  tcfp_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output tcfp_rsp_type rsp_data
);

   localparam int UW = $clog2(MAX_ACTORS + 1);

   // Parse phases.
   localparam logic [4:0] P_IDLE = 5'd0, P_MAGIC = 5'd1, P_TOP_TAG = 5'd2,
      P_TOP_ARITY = 5'd3, P_LIST_TAG = 5'd4, P_LIST_CNT = 5'd5, P_ELEM_TAG = 5'd6,
      P_ELEM_ARITY = 5'd7, P_ACT_TAG = 5'd8, P_ACT_LEN = 5'd9, P_ACT_DATA = 5'd10,
      P_INT_TAG = 5'd11, P_INT_SMALL = 5'd12, P_INT_BE = 5'd13, P_BIG_N = 5'd14,
      P_BIG_SIGN = 5'd15, P_BIG_DIG = 5'd16, P_DL_TAG = 5'd17, P_STR_LEN = 5'd18,
      P_STR_DATA = 5'd19, P_DL_CNT = 5'd20, P_DL_TAIL = 5'd21, P_SEC_TAIL = 5'd22;

   // Control states.
   localparam logic S_RUN = 1'b0, S_SRCH = 1'b1;

   logic          ctl_ff, ctl_in;
   logic [4:0]    phase_ff, phase_in;
   logic [23:0]   bl_ff, bl_in, bl_dec;
   logic [31:0]   outer_ff, outer_in;
   logic [31:0]   inner_ff, inner_in;
   logic [3:0]    fbl_ff, fbl_in, fbl_dec;
   logic [63:0]   vacc_ff, vacc_in, vshift;
   logic [63:0]   aacc_ff, aacc_in;
   logic          dot_ff, dot_in;
   logic [UW-1:0] used_ff, used_in;
   logic [2:0]    dpos_ff, dpos_in;
   tcfp_rsp_type  q0_ff, q0_in, q1_ff, q1_in;
   logic [1:0]    qn_ff, qn_in;

   logic          req_fire, rsp_fire;
   logic [7:0]    b;
   logic          e_val;
   logic [2:0]    e_kind;
   logic [63:0]   e_cnt;
   logic [3:0]    err;
   logic          id_go, ed_go, se_go;
   logic [63:0]   id_v;
   logic          srch_go, wr_en;
   tcfp_srch_type srch;
   tcfp_rsp_type  r_emit, r_err;

   assign req_stall = !((ctl_ff == S_RUN) && (qn_ff == 2'd0));
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = (qn_ff != 2'd0);
   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign rsp_data  = q0_ff;
   assign b         = req_data.data_byte;
   assign bl_dec    = (bl_ff != 24'd0) ? (bl_ff - 24'd1) : 24'd0;
   assign fbl_dec   = fbl_ff - 4'd1;
   assign vshift    = {vacc_ff[55:0], b};

   // Byte parser and result assembly.
   always_comb begin
      ctl_in = ctl_ff; phase_in = phase_ff; bl_in = bl_ff; outer_in = outer_ff;
      inner_in = inner_ff; fbl_in = fbl_ff; vacc_in = vacc_ff; aacc_in = aacc_ff;
      dot_in = dot_ff; used_in = used_ff; dpos_in = dpos_ff;
      q0_in = q0_ff; q1_in = q1_ff; qn_in = qn_ff;
      e_val = 1'b0; e_kind = KIND_PAIR; e_cnt = '0; err = ERR_NONE;
      id_go = 1'b0; ed_go = 1'b0; se_go = 1'b0; id_v = '0;
      srch_go = 1'b0; wr_en = 1'b0;

      // Result queue drains one transfer at a time.
      if (rsp_fire) begin
         q0_in = q1_ff;
         qn_in = qn_ff - 2'd1;
      end

      if (req_fire && !req_data.action) begin
         // Start of a new value.
         phase_in = P_IDLE; outer_in = '0; inner_in = '0; fbl_in = '0;
         vacc_in = '0; aacc_in = '0; dot_in = 1'b0; used_in = '0; dpos_in = '0;
         bl_in = req_data.value_length;
         if (req_data.value_length == 24'd0) begin
            err = ERR_MAGIC;
         end else begin
            phase_in = P_MAGIC;
         end
      end else if (req_fire && (phase_ff != P_IDLE)) begin
         bl_in = bl_dec;
         case (phase_ff)
            P_MAGIC: begin
               if (b != 8'd131) err = ERR_MAGIC;
               else phase_in = P_TOP_TAG;
            end
            P_TOP_TAG, P_ELEM_TAG: begin
               if (b != 8'd104) err = ERR_TUPLE;
               else phase_in = (phase_ff == P_TOP_TAG) ? P_TOP_ARITY : P_ELEM_ARITY;
            end
            P_TOP_ARITY, P_ELEM_ARITY: begin
               if (b != 8'd2) err = ERR_TUPLE;
               else phase_in = (phase_ff == P_TOP_ARITY) ? P_LIST_TAG : P_ACT_TAG;
            end
            P_LIST_TAG: begin
               if (b == 8'd106) begin
                  se_go = 1'b1;
               end else if (b == 8'd108) begin
                  vacc_in = '0; fbl_in = 4'd4; phase_in = P_LIST_CNT;
               end else begin
                  err = ERR_LIST;
               end
            end
            P_LIST_CNT: begin
               vacc_in = vshift; fbl_in = fbl_dec;
               if (fbl_dec == 4'd0) begin
                  if ((vshift == 64'd0) || (vshift > {40'd0, bl_dec})) begin
                     err = ERR_LIST;
                  end else begin
                     outer_in = vshift[31:0]; phase_in = P_ELEM_TAG;
                  end
               end
            end
            P_ACT_TAG: begin
               if ((b != 8'd109) || (bl_dec < 24'(4 + ActorBytes))) begin
                  err = ERR_ACTOR;
               end else begin
                  vacc_in = '0; fbl_in = 4'd4; phase_in = P_ACT_LEN;
               end
            end
            P_ACT_LEN: begin
               vacc_in = vshift; fbl_in = fbl_dec;
               if (fbl_dec == 4'd0) begin
                  if (vshift != 64'(ActorBytes)) begin
                     err = ERR_ACTOR;
                  end else begin
                     aacc_in = '0; vacc_in = '0; fbl_in = 4'(ActorBytes);
                     phase_in = P_ACT_DATA;
                  end
               end
            end
            P_ACT_DATA: begin
               aacc_in = {aacc_ff[55:0], b}; fbl_in = fbl_dec;
               if (fbl_dec == 4'd0) begin
                  srch_go = 1'b1; ctl_in = S_SRCH;
               end
            end
            P_INT_TAG: begin
               if (bl_dec == 24'd0) err = ERR_SHORT;
               else if (b == 8'd97) phase_in = P_INT_SMALL;
               else if (b == 8'd98) begin
                  vacc_in = '0; fbl_in = 4'd4; phase_in = P_INT_BE;
               end else if (b == 8'd110) phase_in = P_BIG_N;
               else err = ERR_INT;
            end
            P_INT_SMALL: begin
               id_go = 1'b1; id_v = {56'd0, b};
            end
            P_INT_BE: begin
               vacc_in = vshift; fbl_in = fbl_dec;
               if (fbl_dec == 4'd0) begin
                  id_go = 1'b1; id_v = vshift;
               end
            end
            P_BIG_N: begin
               vacc_in = {56'd0, b}; phase_in = P_BIG_SIGN;
            end
            P_BIG_SIGN: begin
               if ((vacc_ff > 64'(COUNTER_BYTES)) || (b != 8'd0)) begin
                  err = ERR_BIG;
               end else if (vacc_ff == 64'd0) begin
                  id_go = 1'b1; id_v = '0;
               end else begin
                  fbl_in = vacc_ff[3:0]; dpos_in = '0; vacc_in = '0;
                  phase_in = P_BIG_DIG;
               end
            end
            P_BIG_DIG: begin
               // Little-endian digits land in the byte lane chosen by dpos.
               for (int k = 0; k < 8; k++) begin
                  if (dpos_ff == 3'(k)) vacc_in[8*k +: 8] = vacc_ff[8*k +: 8] | b;
               end
               dpos_in = dpos_ff + 3'd1; fbl_in = fbl_dec;
               if (fbl_dec == 4'd0) begin
                  id_go = 1'b1; id_v = vacc_in;
               end
            end
            P_DL_TAG: begin
               if (b == 8'd106) begin
                  e_val = 1'b1; e_kind = KIND_EMPTY; ed_go = 1'b1;
               end else if (b == 8'd107) begin
                  vacc_in = '0; fbl_in = 4'd2; phase_in = P_STR_LEN;
               end else if (b == 8'd108) begin
                  vacc_in = '0; fbl_in = 4'd4; phase_in = P_DL_CNT;
               end else begin
                  err = ERR_LIST;
               end
            end
            P_STR_LEN: begin
               vacc_in = vshift; fbl_in = fbl_dec;
               if (fbl_dec == 4'd0) begin
                  if (vshift > {40'd0, bl_dec}) err = ERR_COUNT;
                  else if (vshift == 64'd0) begin
                     e_val = 1'b1; e_kind = KIND_EMPTY; ed_go = 1'b1;
                  end else begin
                     inner_in = vshift[31:0]; phase_in = P_STR_DATA;
                  end
               end
            end
            P_STR_DATA: begin
               e_val = 1'b1; e_kind = KIND_DOT; e_cnt = {56'd0, b};
               inner_in = inner_ff - 32'd1;
               if (inner_ff == 32'd1) ed_go = 1'b1;
            end
            P_DL_CNT: begin
               vacc_in = vshift; fbl_in = fbl_dec;
               if (fbl_dec == 4'd0) begin
                  if ((vshift == 64'd0) || (vshift > {40'd0, bl_dec})) begin
                     err = ERR_COUNT;
                  end else begin
                     inner_in = vshift[31:0]; phase_in = P_INT_TAG;
                  end
               end
            end
            P_DL_TAIL: begin
               if (b != 8'd106) err = ERR_TAIL;
               else ed_go = 1'b1;
            end
            P_SEC_TAIL: begin
               if (b != 8'd106) err = ERR_TAIL;
               else se_go = 1'b1;
            end
            default: begin
               phase_in = P_IDLE;
            end
         endcase

         // A completed integer becomes a pair or a dot.
         if (id_go) begin
            e_val = 1'b1; e_cnt = id_v;
            if (!dot_ff) begin
               e_kind = KIND_PAIR; ed_go = 1'b1;
            end else begin
               e_kind = KIND_DOT; inner_in = inner_ff - 32'd1;
               phase_in = (inner_ff == 32'd1) ? P_DL_TAIL : P_INT_TAG;
            end
         end
         // End of one outer list element.
         if (ed_go) begin
            outer_in = outer_ff - 32'd1;
            phase_in = (outer_ff == 32'd1) ? P_SEC_TAIL : P_ELEM_TAG;
         end
         // End of a section: move to the dot cloud or finish.
         if (se_go) begin
            if (!dot_ff) begin
               dot_in = 1'b1; used_in = '0; phase_in = P_LIST_TAG;
            end else begin
               e_val = 1'b1; e_kind = KIND_DONE; phase_in = P_IDLE;
            end
         end
         if (err != ERR_NONE) begin
            phase_in = P_IDLE;
         end else if (!srch_go && (phase_in != P_IDLE) && (bl_dec == 24'd0)) begin
            err = ERR_SHORT; phase_in = P_IDLE;
         end
      end else if ((ctl_ff == S_SRCH) && srch.done) begin
         // Outcome of the duplicate search for the finished actor.
         ctl_in = S_RUN;
         if (srch.dup) begin
            err = ERR_DUP; phase_in = P_IDLE;
         end else if (used_ff >= UW'(MAX_ACTORS)) begin
            err = ERR_FULL; phase_in = P_IDLE;
         end else begin
            wr_en = 1'b1; used_in = used_ff + UW'(1);
            phase_in = dot_ff ? P_DL_TAG : P_INT_TAG;
            if (bl_ff == 24'd0) begin
               err = ERR_SHORT; phase_in = P_IDLE;
            end
         end
      end

      // Load the results of this transfer into the queue.
      r_emit.kind = e_kind; r_emit.actor_id = (e_kind == KIND_DONE) ? 64'd0 : aacc_ff;
      r_emit.event_count = e_cnt; r_emit.error_code = ERR_NONE;
      r_emit.final_res = (err == ERR_NONE);
      r_err.kind = KIND_ERR; r_err.actor_id = '0; r_err.event_count = '0;
      r_err.error_code = err; r_err.final_res = 1'b1;
      if (e_val && (err != ERR_NONE)) begin
         q0_in = r_emit; q1_in = r_err; qn_in = 2'd2;
      end else if (e_val) begin
         q0_in = r_emit; qn_in = 2'd1;
      end else if (err != ERR_NONE) begin
         q0_in = r_err; qn_in = 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= S_RUN; phase_ff <= P_IDLE; bl_ff <= '0; outer_ff <= '0;
         inner_ff <= '0; fbl_ff <= '0; vacc_ff <= '0; aacc_ff <= '0;
         dot_ff <= 1'b0; used_ff <= '0; dpos_ff <= '0; qn_ff <= 2'd0;
      end else begin
         ctl_ff <= ctl_in; phase_ff <= phase_in; bl_ff <= bl_in; outer_ff <= outer_in;
         inner_ff <= inner_in; fbl_ff <= fbl_in; vacc_ff <= vacc_in; aacc_ff <= aacc_in;
         dot_ff <= dot_in; used_ff <= used_in; dpos_ff <= dpos_in; qn_ff <= qn_in;
      end
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   // Actor table and duplicate search unit.
   tcfp_actor_tab #(.MAX_ACTORS(MAX_ACTORS)) u_tab (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_idx   (used_ff),
      .wr_data  (aacc_ff),
      .srch_go  (srch_go),
      .srch_key (aacc_in),
      .srch_cnt (used_ff),
      .srch     (srch)
   );

endmodule

// File: rtl/tcfp_actor_tab.sv
// ----------------------------------------------------------------------------
// tcfp_actor_tab
// Actor table memory with a sequential duplicate search, one entry per cycle.
// ----------------------------------------------------------------------------
module tcfp_actor_tab import tcfp_pkg::*; #(
   parameter int MAX_ACTORS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [$clog2(MAX_ACTORS+1)-1:0]      wr_idx,
   input  logic [63:0]                          wr_data,
   input  logic                                 srch_go,
   input  logic [63:0]                          srch_key,
   input  logic [$clog2(MAX_ACTORS+1)-1:0]      srch_cnt,
   output tcfp_srch_type                        srch
);

   localparam int CW = $clog2(MAX_ACTORS + 1);
   localparam int AW = (MAX_ACTORS > 1) ? $clog2(MAX_ACTORS) : 1;

   logic [63:0]   mem [MAX_ACTORS];
   logic [63:0]   rd_data_ff;
   logic [63:0]   key_ff, key_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] lim_ff, lim_in;
   logic          busy_ff, busy_in;
   logic          chk_ff, chk_in;
   logic          dup_ff, dup_in;
   logic          rd_en;
   logic          fin;

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx[AW-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[idx_ff[AW-1:0]];
      end
   end

   // Search sequencer: issue one read per cycle, compare the returned entry.
   always_comb begin
      key_in  = key_ff;
      idx_in  = idx_ff;
      lim_in  = lim_ff;
      busy_in = busy_ff;
      dup_in  = dup_ff;
      rd_en   = busy_ff && (idx_ff < lim_ff);
      chk_in  = rd_en;
      fin     = busy_ff && !(idx_ff < lim_ff) && !chk_ff;
      if (chk_ff && (rd_data_ff == key_ff)) begin
         dup_in = 1'b1;
      end
      if (rd_en) begin
         idx_in = idx_ff + CW'(1);
      end
      if (fin) begin
         busy_in = 1'b0;
      end
      if (srch_go) begin
         key_in  = srch_key;
         idx_in  = '0;
         lim_in  = srch_cnt;
         busy_in = 1'b1;
         dup_in  = 1'b0;
         chk_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         chk_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         chk_ff  <= chk_in;
      end
      key_ff <= key_in;
      idx_ff <= idx_in;
      lim_ff <= lim_in;
      dup_ff <= dup_in;
   end

   assign srch.done = fin;
   assign srch.dup  = dup_ff;

endmodule

// File: rtl/tcfp_checker.sv
// ----------------------------------------------------------------------------
// tcfp_checker
// Port-level checks of the clock parser, bound to the top level.
// ----------------------------------------------------------------------------
module tcfp_checker import tcfp_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input tcfp_rsp_type rsp_data
);

   // An error result always carries a nonzero code.
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_ERR) |-> (rsp_data.error_code != ERR_NONE))
      else $error("error result without code");

   // Other results carry no error code.
   a_no_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind != KIND_ERR) |-> (rsp_data.error_code == ERR_NONE))
      else $error("code on a non-error result");

   // A done result has no actor or count.
   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_DONE) |->
      (rsp_data.actor_id == 64'd0) && (rsp_data.event_count == 64'd0))
      else $error("done result with payload");

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // While a result waits, no new request transfer is taken.
   a_req_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a result waits");

endmodule

bind term_format_clock_parser tcfp_checker u_tcfp_checker (.*);

// File: sim/term_format_clock_parser_checker.sv
// ----------------------------------------------------------------------------
// term_format_clock_parser_checker
// Watches both channels of the clock parser, predicts its results and checks.
// ----------------------------------------------------------------------------
// Every accepted request transfer is run through a behavioral copy of the
// parser. The results it predicts are queued, and each response transfer is
// compared field by field with the oldest queued result.
module term_format_clock_parser_checker import tcfp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  tcfp_req_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  tcfp_rsp_type rsp_data,
   output int           fail_count,
   output int           pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MaxActors = 16;
   localparam int CounterBytes = 8;

   typedef enum logic [4:0] {
      PH_IDLE, PH_MAGIC, PH_TOP_TAG, PH_TOP_ARITY, PH_LIST_TAG, PH_LIST_CNT,
      PH_ELEM_TAG, PH_ELEM_ARITY, PH_ACT_TAG, PH_ACT_LEN, PH_ACT_DATA,
      PH_INT_TAG, PH_INT_SMALL, PH_INT_BE, PH_BIG_N, PH_BIG_SIGN, PH_BIG_DIG,
      PH_DL_TAG, PH_STR_LEN, PH_STR_DATA, PH_DL_CNT, PH_DL_TAIL, PH_SEC_TAIL
   } phase_type;

   // Parser state mirrored from the block's behavior.
   phase_type   phase;
   logic [23:0] bytes_left;
   logic [31:0] outer_count;
   logic [31:0] inner_count;
   logic [3:0]  field_left;
   logic [63:0] accum;
   logic [63:0] actor;
   logic        dot_section;
   logic [63:0] actor_seen [MaxActors];
   int          actors_used;
   logic [2:0]  digit_pos;

   tcfp_rsp_type expected_results [$];
   tcfp_rsp_type byte_results [$];

   function automatic void add_result(logic [2:0] kind, logic [63:0] act,
                                      logic [63:0] cnt, logic [3:0] code);
      tcfp_rsp_type r;
      r.kind = kind;
      r.actor_id = act;
      r.event_count = cnt;
      r.error_code = code;
      r.final_res = 1'b0;
      byte_results.push_back(r);
   endfunction

   function automatic logic shift_in(logic [7:0] b);
      accum = {accum[55:0], b};
      field_left = field_left - 4'd1;
      return field_left == 0;
   endfunction

   function automatic void open_field(logic [3:0] n, phase_type nxt);
      accum = '0;
      field_left = n;
      phase = nxt;
   endfunction

   function automatic void end_section();
      if (!dot_section) begin
         dot_section = 1'b1;
         actors_used = 0;
         phase = PH_LIST_TAG;
      end else begin
         add_result(KIND_DONE, '0, '0, ERR_NONE);
         phase = PH_IDLE;
      end
   endfunction

   function automatic void end_element();
      outer_count = outer_count - 1;
      phase = (outer_count == 0) ? PH_SEC_TAIL : PH_ELEM_TAG;
   endfunction

   function automatic void end_integer(logic [63:0] v);
      if (!dot_section) begin
         add_result(KIND_PAIR, actor, v, ERR_NONE);
         end_element();
      end else begin
         add_result(KIND_DOT, actor, v, ERR_NONE);
         inner_count = inner_count - 1;
         phase = (inner_count == 0) ? PH_DL_TAIL : PH_INT_TAG;
      end
   endfunction

   // Consumes one data byte; returns an error code or none.
   function automatic logic [3:0] parse_byte(logic [7:0] b);
      case (phase)
         PH_MAGIC: begin
            if (b != 8'd131) return ERR_MAGIC;
            phase = PH_TOP_TAG;
         end
         PH_TOP_TAG, PH_ELEM_TAG: begin
            if (b != 8'd104) return ERR_TUPLE;
            phase = (phase == PH_TOP_TAG) ? PH_TOP_ARITY : PH_ELEM_ARITY;
         end
         PH_TOP_ARITY, PH_ELEM_ARITY: begin
            if (b != 8'd2) return ERR_TUPLE;
            phase = (phase == PH_TOP_ARITY) ? PH_LIST_TAG : PH_ACT_TAG;
         end
         PH_LIST_TAG: begin
            if (b == 8'd106) end_section();
            else if (b == 8'd108) open_field(4'd4, PH_LIST_CNT);
            else return ERR_LIST;
         end
         PH_LIST_CNT: begin
            if (shift_in(b)) begin
               if (accum == 0 || accum > bytes_left) return ERR_LIST;
               outer_count = accum[31:0];
               phase = PH_ELEM_TAG;
            end
         end
         PH_ACT_TAG: begin
            if (b != 8'd109 || bytes_left < 4 + ActorBytes) return ERR_ACTOR;
            open_field(4'd4, PH_ACT_LEN);
         end
         PH_ACT_LEN: begin
            if (shift_in(b)) begin
               if (accum != ActorBytes) return ERR_ACTOR;
               actor = '0;
               open_field(4'(ActorBytes), PH_ACT_DATA);
            end
         end
         PH_ACT_DATA: begin
            actor = {actor[55:0], b};
            field_left = field_left - 4'd1;
            if (field_left == 0) begin
               // Duplicate search only covers actors seen in this section.
               for (int i = 0; i < actors_used; i++)
                  if (actor_seen[i] == actor) return ERR_DUP;
               if (actors_used >= MaxActors) return ERR_FULL;
               actor_seen[actors_used] = actor;
               actors_used++;
               phase = dot_section ? PH_DL_TAG : PH_INT_TAG;
            end
         end
         PH_INT_TAG: begin
            if (bytes_left == 0) return ERR_SHORT;
            if (b == 8'd97) phase = PH_INT_SMALL;
            else if (b == 8'd98) open_field(4'd4, PH_INT_BE);
            else if (b == 8'd110) phase = PH_BIG_N;
            else return ERR_INT;
         end
         PH_INT_SMALL: end_integer({56'd0, b});
         PH_INT_BE: begin
            if (shift_in(b)) end_integer(accum);
         end
         PH_BIG_N: begin
            accum = {56'd0, b};
            phase = PH_BIG_SIGN;
         end
         PH_BIG_SIGN: begin
            if (accum > CounterBytes || b != 0) return ERR_BIG;
            if (accum == 0) begin
               end_integer('0);
            end else begin
               field_left = accum[3:0];
               digit_pos = '0;
               accum = '0;
               phase = PH_BIG_DIG;
            end
         end
         PH_BIG_DIG: begin
            // Bignum digits arrive least significant first.
            accum = accum | ({56'd0, b} << (8 * digit_pos));
            digit_pos = digit_pos + 3'd1;
            field_left = field_left - 4'd1;
            if (field_left == 0) end_integer(accum);
         end
         PH_DL_TAG: begin
            if (b == 8'd106) begin
               add_result(KIND_EMPTY, actor, '0, ERR_NONE);
               end_element();
            end else if (b == 8'd107) open_field(4'd2, PH_STR_LEN);
            else if (b == 8'd108) open_field(4'd4, PH_DL_CNT);
            else return ERR_LIST;
         end
         PH_STR_LEN: begin
            if (shift_in(b)) begin
               if (accum > bytes_left) return ERR_COUNT;
               if (accum == 0) begin
                  add_result(KIND_EMPTY, actor, '0, ERR_NONE);
                  end_element();
               end else begin
                  inner_count = accum[31:0];
                  phase = PH_STR_DATA;
               end
            end
         end
         PH_STR_DATA: begin
            add_result(KIND_DOT, actor, {56'd0, b}, ERR_NONE);
            inner_count = inner_count - 1;
            if (inner_count == 0) end_element();
         end
         PH_DL_CNT: begin
            if (shift_in(b)) begin
               if (accum == 0 || accum > bytes_left) return ERR_COUNT;
               inner_count = accum[31:0];
               phase = PH_INT_TAG;
            end
         end
         PH_DL_TAIL: begin
            if (b != 8'd106) return ERR_TAIL;
            end_element();
         end
         PH_SEC_TAIL: begin
            if (b != 8'd106) return ERR_TAIL;
            end_section();
         end
         default: phase = PH_IDLE;
      endcase
      return ERR_NONE;
   endfunction

   function automatic void clear_state();
      phase = PH_IDLE;
      bytes_left = '0;
      outer_count = '0;
      inner_count = '0;
      field_left = '0;
      accum = '0;
      actor = '0;
      dot_section = 1'b0;
      actors_used = 0;
      digit_pos = '0;
   endfunction

   // Predicts the results of one request transfer and queues them.
   function automatic void predict_transfer(tcfp_req_type req);
      logic [3:0] code;
      byte_results.delete();
      if (!req.action) begin
         clear_state();
         bytes_left = req.value_length;
         if (bytes_left == 0) add_result(KIND_ERR, '0, '0, ERR_MAGIC);
         else phase = PH_MAGIC;
      end else if (phase != PH_IDLE) begin
         if (bytes_left > 0) bytes_left = bytes_left - 24'd1;
         code = parse_byte(req.data_byte);
         if (code != ERR_NONE) begin
            add_result(KIND_ERR, '0, '0, code);
            phase = PH_IDLE;
         end else if (phase != PH_IDLE && bytes_left == 0) begin
            add_result(KIND_ERR, '0, '0, ERR_SHORT);
            phase = PH_IDLE;
         end
      end
      if (byte_results.size() > 0)
         byte_results[byte_results.size() - 1].final_res = 1'b1;
      foreach (byte_results[i]) expected_results.push_back(byte_results[i]);
   endfunction

   // Observe both channels at the rising edge.
   always @(posedge clock) begin
      tcfp_rsp_type want;
      if (reset) begin
         clear_state();
         expected_results.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall) predict_transfer(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               if (fail_count < 10)
                  $display("Unexpected result transfer: %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (want !== rsp_data) begin
                  if (fail_count < 10)
                     $display("Mismatch: expected %p, got %p", want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_count = expected_results.size();
   end

endmodule

// File: sim/term_format_clock_parser_test.sv
// ----------------------------------------------------------------------------
// term_format_clock_parser_test
// Stimulus and verdict for the external term format clock parser.
// ----------------------------------------------------------------------------
// Directed values cover bad magic, duplicate actors and a full table, then
// random well-formed clocks with occasional corruption, truncation and noise
// follow. A separate checker predicts and compares every result transfer.
module term_format_clock_parser_test import tcfp_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   tcfp_req_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   tcfp_rsp_type rsp_data;
   int           fail_count;
   int           pending_count;
   int           byte_total;
   logic         hold_off;

   logic [7:0]  clock_bytes [$];
   logic [63:0] actor_pool [4];

   term_format_clock_parser dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   term_format_clock_parser_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

   // Receiver: random stalls per transfer, with a long hold-off on request.
   initial begin
      int gap;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (60) @(negedge clock);
         end
         gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3));
         if ($urandom_range(0, 7) == 0) gap = 0;
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(negedge clock);
         while (!(rsp_valid && !rsp_stall)) @(negedge clock);
      end
   end

   // One request transfer with a random gap before it.
   task automatic send_item(logic act, logic [23:0] len, logic [7:0] b);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{action: act, value_length: len, data_byte: b};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      byte_total++;
   endtask

   task automatic put_u32(logic [31:0] v);
      for (int i = 3; i >= 0; i--) clock_bytes.push_back(v[8*i +: 8]);
   endtask

   task automatic put_actor(logic [63:0] a);
      clock_bytes.push_back(8'd109);
      put_u32(ActorBytes);
      for (int i = 7; i >= 0; i--) clock_bytes.push_back(a[8*i +: 8]);
   endtask

   // Integer in one of the three encodings.
   task automatic put_integer();
      logic [63:0] v;
      int n;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 2))
         0: begin
            clock_bytes.push_back(8'd97);
            clock_bytes.push_back(v[7:0]);
         end
         1: begin
            clock_bytes.push_back(8'd98);
            put_u32(v[31:0]);
         end
         default: begin
            n = $urandom_range(0, 8);
            clock_bytes.push_back(8'd110);
            clock_bytes.push_back(n[7:0]);
            clock_bytes.push_back(8'd0);
            for (int i = 0; i < n; i++) clock_bytes.push_back(v[8*i +: 8]);
         end
      endcase
   endtask

   function automatic logic [63:0] pick_actor(int k);
      return ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : actor_pool[k];
   endfunction

   // Builds one well-formed clock into clock_bytes.
   task automatic build_clock();
      int n;
      int m;
      int base;
      clock_bytes.delete();
      clock_bytes.push_back(8'd131);
      clock_bytes.push_back(8'd104);
      clock_bytes.push_back(8'd2);
      for (int s = 0; s < 2; s++) begin
         n = $urandom_range(0, 3);
         base = $urandom_range(0, 3);
         if (n == 0) begin
            clock_bytes.push_back(8'd106);
         end else begin
            clock_bytes.push_back(8'd108);
            put_u32(n);
            for (int e = 0; e < n; e++) begin
               clock_bytes.push_back(8'd104);
               clock_bytes.push_back(8'd2);
               put_actor(pick_actor((base + e) % 4));
               if (s == 0) begin
                  put_integer();
               end else begin
                  case ($urandom_range(0, 2))
                     0: clock_bytes.push_back(8'd106);
                     1: begin
                        m = $urandom_range(0, 3);
                        clock_bytes.push_back(8'd107);
                        clock_bytes.push_back(8'd0);
                        clock_bytes.push_back(m[7:0]);
                        for (int i = 0; i < m; i++)
                           clock_bytes.push_back(8'($urandom_range(0, 255)));
                     end
                     default: begin
                        m = $urandom_range(1, 3);
                        clock_bytes.push_back(8'd108);
                        put_u32(m);
                        for (int i = 0; i < m; i++) put_integer();
                        clock_bytes.push_back(8'd106);
                     end
                  endcase
               end
            end
            clock_bytes.push_back(8'd106);
         end
      end
   endtask

   // Sends the queued bytes with a start, optionally mangled.
   task automatic send_clock(bit mangle);
      int len;
      int pos;
      len = clock_bytes.size();
      if (mangle) begin
         case ($urandom_range(0, 3))
            0: len = $urandom_range(1, len);
            1: len = len + $urandom_range(0, 4);
            default: begin
               pos = $urandom_range(0, clock_bytes.size() - 1);
               clock_bytes[pos] = 8'($urandom_range(0, 255));
            end
         endcase
      end
      send_item(1'b0, len[23:0], 8'($urandom));
      foreach (clock_bytes[i]) send_item(1'b1, 24'($urandom), clock_bytes[i]);
      for (int i = clock_bytes.size(); i < len; i++)
         send_item(1'b1, 24'($urandom), 8'($urandom));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      hold_off = 1'b0;
      byte_total = 0;
      foreach (actor_pool[i]) actor_pool[i] = {$urandom, $urandom};
      actor_pool[0] = '0;
      actor_pool[1] = '1;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Directed: idle bytes, zero length, maximum length, bad magic.
      send_item(1'b1, 24'hFFFFFF, 8'hFF);
      send_item(1'b0, 24'd0, 8'h00);
      send_item(1'b0, 24'hFFFFFF, 8'hAA);
      send_item(1'b1, 24'd0, 8'd130);
      send_item(1'b1, 24'd0, 8'h55);
      // Empty clock, then a restart midway.
      clock_bytes = '{8'd131, 8'd104, 8'd2, 8'd106, 8'd106};
      send_clock(1'b0);
      send_item(1'b0, 24'd9, 8'h00);
      send_item(1'b1, 24'd0, 8'd131);
      // Duplicate actor in one section.
      clock_bytes = '{8'd131, 8'd104, 8'd2, 8'd108};
      put_u32(2);
      for (int i = 0; i < 2; i++) begin
         clock_bytes.push_back(8'd104);
         clock_bytes.push_back(8'd2);
         put_actor(actor_pool[1]);
         clock_bytes.push_back(8'd97);
         clock_bytes.push_back(8'd7);
      end
      send_clock(1'b0);
      // Table full: seventeen distinct actors in the dot cloud.
      clock_bytes = '{8'd131, 8'd104, 8'd2, 8'd106, 8'd108};
      put_u32(17);
      for (int i = 0; i < 17; i++) begin
         clock_bytes.push_back(8'd104);
         clock_bytes.push_back(8'd2);
         put_actor({32'hA5A5_0000, i});
         clock_bytes.push_back(8'd106);
      end
      clock_bytes.push_back(8'd106);
      send_clock(1'b0);
      wait_drained();

      // Long receiver hold-off while the sender keeps offering.
      hold_off = 1'b1;
      build_clock();
      send_clock(1'b0);
      hold_off = 1'b0;

      // Random clocks, most well formed, some mangled, some noise.
      while (byte_total < 1000) begin
         if ($urandom_range(0, 9) == 0) begin
            send_item(1'($urandom_range(0, 1)), 24'($urandom_range(0, 40)),
                      8'($urandom));
         end else begin
            build_clock();
            send_clock($urandom_range(0, 3) == 0);
         end
         if ($urandom_range(0, 19) == 0) wait_drained();
      end

      wait_drained();
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// File: term_format_clock_parser.f
rtl/tcfp_pkg.sv
rtl/tcfp_actor_tab.sv
rtl/term_format_clock_parser.sv
rtl/tcfp_checker.sv
sim/term_format_clock_parser_checker.sv
sim/term_format_clock_parser_test.sv
